// ----- sv/ipv4p_pkg.sv -----
// Types and character constants shared by the IPv4 dotted-decimal parser.
package ipv4p_pkg;

    localparam int unsigned OCTET_W     = 8;
    localparam int unsigned OCTET_COUNT = 4;
    localparam int unsigned IDX_W       = 2;
    localparam int unsigned BEGUN_W     = 3;
    localparam int unsigned ADDR_W      = 32;
    localparam int unsigned PROD_W      = 12;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [PROD_W-1:0]  OCTET_MAX   = 12'd255;
    localparam logic [BEGUN_W-1:0] BEGUN_FULL  = 3'd4;

    typedef struct packed {
        logic [7:0] ch;
        logic       first;
    } t_in;

    typedef struct packed {
        logic              ok;
        logic [ADDR_W-1:0] address;
    } t_out;

    typedef struct packed {
        logic valid;
        t_out data;
    } t_res;

endpackage

// ----- sv/ipv4_dotted_decimal_parser_top.sv -----
// Top level of the IPv4 dotted-decimal parser: request and result registers.
// The parser takes the text of an IPv4 address one character per request,
// with first set on the opening character of each string, and gives one
// result on the character that decides the string: ok with the 32-bit
// address (first octet in bits 31..24) on a NUL, '/' or '-' after four
// octets, or a failure (ok low, address zero) on an octet above 255, a
// fifth octet, a misplaced dot or any other character. Characters after a
// result are dropped without a result until the next first marker. Rate:
// one character per clock cycle, sustained, whenever the result side is
// ready; the request register holds a character and the result register
// its result. The figure is set by the single parse-state update per
// cycle (octet times ten plus digit, one 12-bit add and compare).
module ipv4_dotted_decimal_parser_top
    import ipv4p_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    logic r_in_valid;
    t_in  r_in;
    logic r_out_valid;
    t_out r_out;

    logic can_adv;
    logic adv;
    t_res res;

    // The parse stage may move whenever the result register is free or
    // is being emptied this cycle
    assign can_adv    = !r_out_valid || i_out_ready;
    assign adv        = r_in_valid && can_adv;
    assign o_in_ready = !r_in_valid || can_adv;

    // Hold the accepted character until the parse stage takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    ipv4p_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_char  (r_in),
        .o_res   (res)
    );

    // Capture a result only for a character that decides its string
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (can_adv) begin
            r_out_valid <= adv && res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (can_adv) begin
            r_out <= res.data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- sv/ipv4p_parse.sv -----
// Parse state and per-character update of the IPv4 dotted-decimal parser.
module ipv4p_parse
    import ipv4p_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_adv,
    input  t_in  i_char,
    output t_res o_res
);

    logic                 r_active;
    logic                 r_saw_digit;
    logic [BEGUN_W-1:0]   r_begun;
    logic [IDX_W-1:0]     r_index;
    logic [OCTET_W-1:0]   r_oct [OCTET_COUNT];

    logic                 n_active;
    logic                 n_saw_digit;
    logic [BEGUN_W-1:0]   n_begun;
    logic [IDX_W-1:0]     n_index;
    logic [OCTET_W-1:0]   n_oct [OCTET_COUNT];

    logic [OCTET_W-1:0]   e_oct [OCTET_COUNT];
    logic [OCTET_W-1:0]   cur;
    logic [PROD_W-1:0]    value;
    logic [IDX_W-1:0]     nxt_idx;
    logic                 is_term;
    logic                 is_digit;
    logic                 full;
    logic                 res_valid;
    logic                 res_ok;

    always_comb begin
        // A first marker clears the parse before the character is looked at
        if (i_char.first) begin
            n_active    = 1'b1;
            n_saw_digit = 1'b0;
            n_begun     = '0;
            n_index     = '0;
            for (int k = 0; k < OCTET_COUNT; k++) begin
                e_oct[k] = '0;
            end
        end else begin
            n_active    = r_active;
            n_saw_digit = r_saw_digit;
            n_begun     = r_begun;
            n_index     = r_index;
            for (int k = 0; k < OCTET_COUNT; k++) begin
                e_oct[k] = r_oct[k];
            end
        end
        n_oct = e_oct;

        cur      = e_oct[n_index];
        value    = {1'b0, cur, 3'b000} + {3'b000, cur, 1'b0}
                 + {8'd0, i_char.ch[3:0] - CH_ZERO[3:0]};
        nxt_idx  = n_index + 1'b1;
        full     = (n_begun >= BEGUN_FULL);
        is_term  = (i_char.ch == CH_NUL) || (i_char.ch == CH_SLASH)
                || (i_char.ch == CH_DASH);
        is_digit = (i_char.ch >= CH_ZERO) && (i_char.ch <= CH_NINE);

        res_valid = 1'b0;
        res_ok    = 1'b0;

        if (n_active) begin
            if (is_term) begin
                res_valid = 1'b1;
                res_ok    = full;
            end else if (is_digit) begin
                if (value > OCTET_MAX) begin
                    res_valid = 1'b1;
                end else begin
                    n_oct[n_index] = value[OCTET_W-1:0];
                    if (!n_saw_digit) begin
                        if (full) begin
                            res_valid = 1'b1;
                        end else begin
                            n_begun     = n_begun + 1'b1;
                            n_saw_digit = 1'b1;
                        end
                    end
                end
            end else if ((i_char.ch == CH_DOT) && n_saw_digit) begin
                if (full) begin
                    res_valid = 1'b1;
                end else begin
                    n_index        = nxt_idx;
                    n_oct[nxt_idx] = '0;
                    n_saw_digit    = 1'b0;
                end
            end else begin
                res_valid = 1'b1;
            end
            if (res_valid) begin
                n_active = 1'b0;
            end
        end
    end

    assign o_res.valid        = res_valid;
    assign o_res.data.ok      = res_ok;
    assign o_res.data.address = res_ok ? {e_oct[0], e_oct[1], e_oct[2], e_oct[3]}
                                       : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_saw_digit <= 1'b0;
            r_begun     <= '0;
            r_index     <= '0;
        end else if (i_adv) begin
            r_active    <= n_active;
            r_saw_digit <= n_saw_digit;
            r_begun     <= n_begun;
            r_index     <= n_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_oct <= n_oct;
        end
    end

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for the IPv4 dotted-decimal parser top level.
module tb_top;
    import ipv4p_pkg::*;

    // How the result of a request is known: from the parse model, or typed in.
    typedef enum logic [1:0] {
        EXP_MODEL,
        EXP_NONE,
        EXP_OK,
        EXP_FAIL
    } t_exp_kind;

    typedef struct {
        logic [7:0]        ch;
        logic              first;
        t_exp_kind         kind;
        logic [ADDR_W-1:0] addr;
    } t_dir_row;

    localparam int unsigned CYCLE_LIMIT  = 300000;
    localparam int unsigned RANDOM_REQS  = 1050;
    localparam int unsigned LONG_HOLD    = 400;
    localparam int unsigned SHOW_FAULTS  = 10;
    localparam int unsigned TX_IDLE [3]  = '{8, 83, 0};
    localparam int unsigned RX_IDLE [3]  = '{83, 8, 0};

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in  i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out_data;

    // Side information that travels with each request, for the typed rows.
    t_exp_kind         req_kind = EXP_MODEL;
    logic [ADDR_W-1:0] req_addr = '0;

    // Parse state of the predictor.
    bit              st_active;
    bit              st_saw_digit;
    bit [BEGUN_W-1:0] st_begun;
    bit [IDX_W-1:0]  st_idx;
    bit [OCTET_W-1:0] st_oct [OCTET_COUNT];

    t_out        parsed_due [$];
    int unsigned live_reqs;
    int unsigned faults;
    int unsigned cycle_count;
    int unsigned tx_idle_pct = TX_IDLE[0];
    int unsigned rx_idle_pct = RX_IDLE[0];
    bit          hold_wanted;
    bit          hold_taken;
    int unsigned hold_left;

    // Directed requests: a reset-time idle character, a full address with a
    // leading zero in its last octet, characters after a result, an octet
    // above 255, a dot with no digit, an unfinished string cut by a new first
    // marker, a NUL with too few octets and an all-ones byte as a bad character.
    t_dir_row dir_rows [24] = '{
        '{8'hFF,    1'b0, EXP_NONE,  '0},
        '{"2",      1'b1, EXP_MODEL, '0},
        '{"5",      1'b0, EXP_MODEL, '0},
        '{"5",      1'b0, EXP_MODEL, '0},
        '{CH_DOT,   1'b0, EXP_MODEL, '0},
        '{"0",      1'b0, EXP_MODEL, '0},
        '{CH_DOT,   1'b0, EXP_MODEL, '0},
        '{"0",      1'b0, EXP_MODEL, '0},
        '{CH_DOT,   1'b0, EXP_MODEL, '0},
        '{"0",      1'b0, EXP_MODEL, '0},
        '{"1",      1'b0, EXP_MODEL, '0},
        '{"0",      1'b0, EXP_MODEL, '0},
        '{CH_DASH,  1'b0, EXP_OK,    32'hFF00_000A},
        '{"7",      1'b0, EXP_NONE,  '0},
        '{"2",      1'b1, EXP_MODEL, '0},
        '{"5",      1'b0, EXP_MODEL, '0},
        '{"6",      1'b0, EXP_FAIL,  '0},
        '{CH_DOT,   1'b1, EXP_FAIL,  '0},
        '{"9",      1'b1, EXP_MODEL, '0},
        '{CH_SLASH, 1'b1, EXP_FAIL,  '0},
        '{"8",      1'b1, EXP_MODEL, '0},
        '{CH_NUL,   1'b0, EXP_FAIL,  '0},
        '{"3",      1'b1, EXP_MODEL, '0},
        '{8'hFF,    1'b0, EXP_FAIL,  '0}
    };

    ipv4_dotted_decimal_parser_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    // Close the string under parse: build the result and leave the active state.
    function automatic bit close_parse(input bit good, output t_out res);
        res.ok      = good;
        res.address = good ? {st_oct[0], st_oct[1], st_oct[2], st_oct[3]} : '0;
        st_active   = 1'b0;
        return 1'b1;
    endfunction

    // Advance the parse by one character; return 1 when the character decides
    // the string. live is raised when the character was not simply dropped.
    function automatic bit parse_char(input t_in req, output t_out res, output bit live);
        logic [PROD_W-1:0] sum;
        res  = '0;
        live = 1'b0;
        if (req.first) begin
            st_active    = 1'b1;
            st_saw_digit = 1'b0;
            st_begun     = '0;
            st_idx       = '0;
            foreach (st_oct[i]) st_oct[i] = '0;
        end
        if (!st_active) return 1'b0;
        live = 1'b1;
        if (req.ch == CH_NUL || req.ch == CH_SLASH || req.ch == CH_DASH) begin
            return close_parse(st_begun >= BEGUN_FULL, res);
        end
        if (req.ch >= CH_ZERO && req.ch <= CH_NINE) begin
            sum = PROD_W'(st_oct[st_idx] * 10 + (req.ch - CH_ZERO));
            if (sum > OCTET_MAX) return close_parse(1'b0, res);
            st_oct[st_idx] = sum[OCTET_W-1:0];
            if (!st_saw_digit) begin
                if (st_begun >= BEGUN_FULL) return close_parse(1'b0, res);
                st_begun     = st_begun + 1'b1;
                st_saw_digit = 1'b1;
            end
            return 1'b0;
        end
        if (req.ch == CH_DOT && st_saw_digit) begin
            if (st_begun >= BEGUN_FULL) return close_parse(1'b0, res);
            st_idx         = st_idx + 1'b1;
            st_oct[st_idx] = '0;
            st_saw_digit   = 1'b0;
            return 1'b0;
        end
        return close_parse(1'b0, res);
    endfunction

    function automatic void log_fault(input string msg);
        faults++;
        if (faults <= SHOW_FAULTS) $display("%s", msg);
    endfunction

    // Run the predictor on every accepted request; typed rows override it.
    always @(posedge i_clk) begin : take_request
        t_out res;
        bit   decided;
        bit   live;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            decided = parse_char(i_in_data, res, live);
            if (live) live_reqs++;
            case (req_kind)
                EXP_NONE: begin
                    decided = 1'b0;
                end
                EXP_OK: begin
                    decided     = 1'b1;
                    res.ok      = 1'b1;
                    res.address = req_addr;
                end
                EXP_FAIL: begin
                    decided = 1'b1;
                    res     = '0;
                end
                default: begin
                end
            endcase
            if (decided) parsed_due.push_back(res);
        end
    end

    // Compare each accepted result with the oldest one due.
    always @(posedge i_clk) begin : check_result
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (parsed_due.size() == 0) begin
                log_fault($sformatf("unexpected result: ok=%0d address=%h",
                                    o_out_data.ok, o_out_data.address));
            end else begin
                want = parsed_due.pop_front();
                if (o_out_data.ok !== want.ok || o_out_data.address !== want.address) begin
                    log_fault($sformatf("result mismatch: want ok=%0d address=%h, got ok=%0d address=%h",
                                        want.ok, want.address,
                                        o_out_data.ok, o_out_data.address));
                end
            end
        end
    end

    // Receiver: stall at random, and once hold off for a long stretch so that
    // the block fills up and has to stall its request side.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (hold_wanted && !hold_taken) begin
            hold_left   <= LONG_HOLD;
            hold_taken  <= 1'b1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Watchdog: end the run if it hangs.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Offer one request, idling first at random; return once it is accepted.
    task automatic send_req(input logic [7:0] ch, input logic first,
                            input t_exp_kind kind, input logic [ADDR_W-1:0] addr);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= '{ch: ch, first: first};
        req_kind   <= kind;
        req_addr   <= addr;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Drop valid and hold until every result due has come back.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (parsed_due.size() != 0) @(posedge i_clk);
    endtask

    // Build one address string, mostly well formed, and send it character by
    // character. Broken forms: too few octets, a fifth octet, an octet above
    // 255, a stray byte, an extra dot, a missing terminator and plain noise.
    task automatic send_random_string();
        logic [7:0]  text [$];
        string       digits;
        int unsigned mode;
        int unsigned n_oct;
        int unsigned bad_oct;
        int unsigned v;
        bit          first_flag;
        mode    = $urandom_range(99);
        n_oct   = OCTET_COUNT;
        bad_oct = OCTET_COUNT + 1;
        if (mode >= 60 && mode < 66) n_oct = $urandom_range(3, 1);
        if (mode >= 66 && mode < 72) n_oct = OCTET_COUNT + 1;
        if (mode >= 72 && mode < 78) bad_oct = $urandom_range(OCTET_COUNT - 1);
        for (int o = 0; o < n_oct; o++) begin
            if (o != 0) text.push_back(CH_DOT);
            case ($urandom_range(3))
                0:       v = 0;
                1:       v = 255;
                default: v = $urandom_range(255);
            endcase
            if (o == bad_oct) v = $urandom_range(999, 256);
            if ($urandom_range(4) == 0) repeat ($urandom_range(2, 1)) text.push_back(CH_ZERO);
            digits = $sformatf("%0d", v);
            for (int d = 0; d < digits.len(); d++) text.push_back(digits[d]);
        end
        if (mode >= 78 && mode < 84) text[$urandom_range(text.size() - 1)] = 8'($urandom_range(255));
        if (mode >= 84 && mode < 88) text.insert($urandom_range(text.size()), CH_DOT);
        // Leave the terminator off now and then: the next first marker cuts in.
        if (mode < 88 || mode >= 94) begin
            case ($urandom_range(2))
                0:       text.push_back(CH_NUL);
                1:       text.push_back(CH_SLASH);
                default: text.push_back(CH_DASH);
            endcase
        end
        if (mode >= 94) begin
            text.delete();
            repeat ($urandom_range(4, 1)) text.push_back(8'($urandom_range(255)));
        end
        // Trailing bytes after the deciding one are dropped by the block.
        if ($urandom_range(3) == 0) begin
            repeat ($urandom_range(3, 1)) text.push_back(8'($urandom_range(255)));
        end
        // Now and then omit the first marker, so the string runs on from the last one.
        first_flag = ($urandom_range(19) != 0);
        foreach (text[i]) send_req(text[i], (i == 0) ? first_flag : 1'b0, EXP_MODEL, '0);
    endtask

    initial begin
        int unsigned base;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table.
        foreach (dir_rows[r]) begin
            send_req(dir_rows[r].ch, dir_rows[r].first, dir_rows[r].kind, dir_rows[r].addr);
        end
        drain();

        // Random strings in three phases of idling; the last one has none and
        // carries the long receiver hold-off. Pause for a full drain between.
        base = live_reqs;
        for (int p = 0; p < 3; p++) begin
            tx_idle_pct = TX_IDLE[p];
            rx_idle_pct = RX_IDLE[p];
            if (p == 2) hold_wanted = 1'b1;
            while (live_reqs < base + (p + 1) * RANDOM_REQS / 3) send_random_string();
            drain();
        end

        // Let the pipeline settle so any stray result is caught.
        repeat (20) @(posedge i_clk);
        if (faults == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ----- ipv4_dotted_decimal_parser_top.f -----
sv/ipv4p_pkg.sv
sv/ipv4p_parse.sv
sv/ipv4_dotted_decimal_parser_top.sv
dv/tb_top.sv
